[rtl/vnf_pkg.sv]
// Shared types, constants and helper functions for the value-noise fBm block.
// Used by vnf_mul, vnf_seq and the top level; depends on nothing.
`default_nettype none

package vnf_pkg;

    // Field and register widths
    localparam int COORD_W  = 32;
    localparam int NOISE_W  = 32;
    localparam int CFG_W    = 5;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 3;

    // Parameter defaults handed down from the top level
    localparam int MAX_OCTAVES_DEF     = 16;
    localparam int COORD_FRAC_BITS_DEF = 16;

    // Register map (word index taken from paddr above the byte offset)
    localparam logic IDX_OCTAVE = 1'b0;
    localparam logic [CFG_W-1:0] OCTAVE_RESET = 5'd4;

    // Shared multiplier: signed operands, full product
    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;

    // Datapath widths
    localparam int LAT_W  = 32;   // lattice index and hash word
    localparam int FRAC_W = 16;   // Q0.16 fraction
    localparam int SM_W   = 17;   // smoothstep weight
    localparam int VAL_W  = 33;   // corner and interpolated values

    // Arithmetic constants
    localparam logic [17:0]      SMOOTH_THREE = 18'd196608;   // 3 in Q2.16
    localparam int               SMOOTH_SHIFT = 32;
    localparam int               LERP_SHIFT   = 16;
    localparam logic [LAT_W-1:0] LAT_MUL_X    = 32'd1000;
    localparam logic [LAT_W-1:0] LAT_MUL_Y    = 32'd57000;
    localparam logic [LAT_W-1:0] LAT_MUL_XY   = 32'd58000;
    localparam logic [LAT_W-1:0] HASH_C1      = 32'd15731;
    localparam logic [LAT_W-1:0] HASH_C2      = 32'd789221;
    localparam logic [LAT_W-1:0] HASH_C3      = 32'd1376312589;
    localparam logic [LAT_W-1:0] ONE_Q30      = 32'h4000_0000;
    localparam int               HASH_SHIFT   = 13;

    // Corner order: (0,0), (1,0), (0,1), (1,1)
    localparam logic [1:0] CORNER_00 = 2'd0;
    localparam logic [1:0] CORNER_10 = 2'd1;
    localparam logic [1:0] CORNER_01 = 2'd2;
    localparam logic [1:0] CORNER_11 = 2'd3;

    typedef struct packed {
        logic             start;
        logic             ack;
        logic [CFG_W-1:0] count;
    } t_seq_ctl;

    typedef struct packed {
        logic               idle;
        logic               done;
        logic [NOISE_W-1:0] sum;
    } t_seq_stat;

    // Offset of a corner's hash seed from the (0,0) seed
    function automatic logic [LAT_W-1:0] corner_offset(input logic [1:0] corner);
        logic [LAT_W-1:0] off;
        case (corner)
            CORNER_00: off = '0;
            CORNER_10: off = LAT_MUL_X;
            CORNER_01: off = LAT_MUL_Y;
            default:   off = LAT_MUL_XY;
        endcase
        return off;
    endfunction

    // Shift-xor stage of the integer hash
    function automatic logic [LAT_W-1:0] hash_mix(input logic [LAT_W-1:0] n);
        return n ^ (n << HASH_SHIFT);
    endfunction

    // Final hash add, 31-bit mask and mapping to 1 - m/2^30 in Q2.30
    function automatic logic signed [VAL_W-1:0] corner_val(input logic [LAT_W-1:0] p);
        logic [LAT_W-1:0] t;
        t = p + HASH_C3;
        return VAL_W'(ONE_Q30) - VAL_W'(t[30:0]);
    endfunction

endpackage

`default_nettype wire

[rtl/vnf_mul.sv]
// Shared signed multiplier with a registered full-width product.
// Depends on vnf_pkg for the default operand width.
`default_nettype none

module vnf_mul #(
    parameter int W = vnf_pkg::MUL_W
) (
    input  wire logic                  i_clk,
    input  wire logic signed [W-1:0]   i_a,
    input  wire logic signed [W-1:0]   i_b,
    output logic signed [2*W-1:0]      o_prod
);

    logic signed [2*W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

[rtl/vnf_seq.sv]
// Octave sequencer: steps one point through all octaves on the shared multiplier.
// Depends on vnf_pkg and instantiates vnf_mul.
`default_nettype none

module vnf_seq #(
    parameter int MAX_OCTAVES     = vnf_pkg::MAX_OCTAVES_DEF,
    parameter int COORD_FRAC_BITS = vnf_pkg::COORD_FRAC_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire vnf_pkg::t_seq_ctl                 i_ctl,
    input  wire logic signed [vnf_pkg::COORD_W-1:0] i_x,
    input  wire logic signed [vnf_pkg::COORD_W-1:0] i_y,
    output vnf_pkg::t_seq_stat                     o_stat
);

    localparam int OIW = $clog2(MAX_OCTAVES + 1);
    localparam int SXW = ((COORD_FRAC_BITS > MAX_OCTAVES) ? COORD_FRAC_BITS : MAX_OCTAVES)
                         + vnf_pkg::COORD_W;
    localparam int FR  = (COORD_FRAC_BITS >= vnf_pkg::FRAC_W) ?
                         COORD_FRAC_BITS - vnf_pkg::FRAC_W : 0;
    localparam int FL  = (COORD_FRAC_BITS < vnf_pkg::FRAC_W) ?
                         vnf_pkg::FRAC_W - COORD_FRAC_BITS : 0;
    localparam int FTW = COORD_FRAC_BITS + FL;

    typedef enum logic [4:0] {
        S_IDLE, S_SQX, S_SMX, S_SQY, S_SMY, S_NX, S_NY, S_NB,
        S_HSQ, S_HK, S_HMUL, S_L0, S_L1, S_L2, S_L3, S_L4, S_DONE
    } t_state;

    t_state                                   r_state;
    logic [OIW-1:0]                           r_oct;
    logic [OIW-1:0]                           r_cnt;
    logic signed [SXW-1:0]                    r_sx;
    logic signed [SXW-1:0]                    r_sy;
    logic [vnf_pkg::SM_W-1:0]                 r_sfx;
    logic [vnf_pkg::SM_W-1:0]                 r_sfy;
    logic [vnf_pkg::LAT_W-1:0]                r_n;
    logic [vnf_pkg::LAT_W-1:0]                r_nb;
    logic [vnf_pkg::LAT_W-1:0]                r_h;
    logic [1:0]                               r_corner;
    logic signed [vnf_pkg::VAL_W-1:0]         r_v [4];
    logic signed [vnf_pkg::VAL_W-1:0]         r_r0;
    logic signed [vnf_pkg::VAL_W-1:0]         r_r1;
    logic [vnf_pkg::NOISE_W-1:0]              r_sum;

    logic signed [vnf_pkg::MUL_W-1:0]         mul_a;
    logic signed [vnf_pkg::MUL_W-1:0]         mul_b;
    logic signed [vnf_pkg::PROD_W-1:0]        prod;
    logic signed [vnf_pkg::PROD_W-1:0]        prod_lerp;
    logic signed [vnf_pkg::VAL_W-1:0]         lerp_step;
    logic signed [vnf_pkg::VAL_W-1:0]         noise;
    logic signed [vnf_pkg::VAL_W-1:0]         contrib;
    logic [vnf_pkg::LAT_W-1:0]                lx;
    logic [vnf_pkg::LAT_W-1:0]                ly;
    logic [FTW-1:0]                           fx_raw;
    logic [FTW-1:0]                           fy_raw;
    logic [vnf_pkg::FRAC_W-1:0]               fx;
    logic [vnf_pkg::FRAC_W-1:0]               fy;
    logic [17:0]                              tx;
    logic [17:0]                              ty;
    logic [vnf_pkg::LAT_W-1:0]                h_comb;
    logic [OIW-1:0]                           oct_next;
    logic [OIW-1:0]                           cnt_sat;

    vnf_mul #(.W(vnf_pkg::MUL_W)) u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // Lattice index and Q0.16 fraction of the scaled point
    assign lx     = r_sx[COORD_FRAC_BITS +: vnf_pkg::LAT_W];
    assign ly     = r_sy[COORD_FRAC_BITS +: vnf_pkg::LAT_W];
    assign fx_raw = FTW'(r_sx[COORD_FRAC_BITS-1:0]);
    assign fy_raw = FTW'(r_sy[COORD_FRAC_BITS-1:0]);
    assign fx     = vnf_pkg::FRAC_W'((fx_raw >> FR) << FL);
    assign fy     = vnf_pkg::FRAC_W'((fy_raw >> FR) << FL);
    assign tx     = vnf_pkg::SMOOTH_THREE - {1'b0, fx, 1'b0};
    assign ty     = vnf_pkg::SMOOTH_THREE - {1'b0, fy, 1'b0};

    assign h_comb    = vnf_pkg::hash_mix(r_nb + vnf_pkg::corner_offset(r_corner));
    assign prod_lerp = prod >>> vnf_pkg::LERP_SHIFT;
    assign lerp_step = vnf_pkg::VAL_W'(prod_lerp);
    assign noise     = r_r0 + lerp_step;
    assign oct_next  = r_oct + OIW'(1);
    assign contrib   = noise >>> oct_next;
    assign cnt_sat   = (i_ctl.count > vnf_pkg::CFG_W'(MAX_OCTAVES)) ?
                       OIW'(MAX_OCTAVES) : OIW'(i_ctl.count);

    // Operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_SQX: begin
                mul_a = vnf_pkg::MUL_W'(fx);
                mul_b = vnf_pkg::MUL_W'(fx);
            end
            S_SMX: begin
                mul_a = vnf_pkg::MUL_W'(prod[31:0]);
                mul_b = vnf_pkg::MUL_W'(tx);
            end
            S_SQY: begin
                mul_a = vnf_pkg::MUL_W'(fy);
                mul_b = vnf_pkg::MUL_W'(fy);
            end
            S_SMY: begin
                mul_a = vnf_pkg::MUL_W'(prod[31:0]);
                mul_b = vnf_pkg::MUL_W'(ty);
            end
            S_NX: begin
                mul_a = vnf_pkg::MUL_W'(lx);
                mul_b = vnf_pkg::MUL_W'(vnf_pkg::LAT_MUL_X);
            end
            S_NY: begin
                mul_a = vnf_pkg::MUL_W'(ly);
                mul_b = vnf_pkg::MUL_W'(vnf_pkg::LAT_MUL_Y);
            end
            S_HSQ: begin
                mul_a = vnf_pkg::MUL_W'(h_comb);
                mul_b = vnf_pkg::MUL_W'(h_comb);
            end
            S_HK: begin
                mul_a = vnf_pkg::MUL_W'(prod[31:0]);
                mul_b = vnf_pkg::MUL_W'(vnf_pkg::HASH_C1);
            end
            S_HMUL: begin
                mul_a = vnf_pkg::MUL_W'(r_h);
                mul_b = vnf_pkg::MUL_W'(prod[31:0] + vnf_pkg::HASH_C2);
            end
            S_L0: begin
                mul_a = r_v[1] - r_v[0];
                mul_b = vnf_pkg::MUL_W'(r_sfx);
            end
            S_L1: begin
                mul_a = r_v[3] - r_v[2];
                mul_b = vnf_pkg::MUL_W'(r_sfx);
            end
            S_L3: begin
                mul_a = r_r1 - r_r0;
                mul_b = vnf_pkg::MUL_W'(r_sfy);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_oct   <= '0;
            r_cnt   <= '0;
            r_sum   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_ctl.start) begin
                        r_sx  <= SXW'(i_x);
                        r_sy  <= SXW'(i_y);
                        r_cnt <= cnt_sat;
                        r_oct <= '0;
                        r_sum <= '0;
                        r_state <= (cnt_sat == '0) ? S_DONE : S_SQX;
                    end
                end
                S_SQX: r_state <= S_SMX;
                S_SMX: r_state <= S_SQY;
                S_SQY: begin
                    r_sfx   <= prod[vnf_pkg::SMOOTH_SHIFT +: vnf_pkg::SM_W];
                    r_state <= S_SMY;
                end
                S_SMY: r_state <= S_NX;
                S_NX: begin
                    r_sfy   <= prod[vnf_pkg::SMOOTH_SHIFT +: vnf_pkg::SM_W];
                    r_state <= S_NY;
                end
                S_NY: begin
                    r_n     <= prod[31:0];
                    r_state <= S_NB;
                end
                S_NB: begin
                    r_nb     <= r_n + prod[31:0];
                    r_corner <= vnf_pkg::CORNER_00;
                    r_state  <= S_HSQ;
                end
                S_HSQ: begin
                    // retire the previous corner while the next one starts
                    if (r_corner != vnf_pkg::CORNER_00) begin
                        r_v[r_corner - 2'd1] <= vnf_pkg::corner_val(prod[31:0]);
                    end
                    r_h     <= h_comb;
                    r_state <= S_HK;
                end
                S_HK: r_state <= S_HMUL;
                S_HMUL: begin
                    if (r_corner == vnf_pkg::CORNER_11) begin
                        r_state <= S_L0;
                    end else begin
                        r_corner <= r_corner + 2'd1;
                        r_state  <= S_HSQ;
                    end
                end
                S_L0: begin
                    r_v[3]  <= vnf_pkg::corner_val(prod[31:0]);
                    r_state <= S_L1;
                end
                S_L1: begin
                    r_r0    <= r_v[0] + lerp_step;
                    r_state <= S_L2;
                end
                S_L2: begin
                    r_r1    <= r_v[2] + lerp_step;
                    r_state <= S_L3;
                end
                S_L3: r_state <= S_L4;
                S_L4: begin
                    r_sum <= r_sum + vnf_pkg::NOISE_W'(contrib);
                    r_sx  <= r_sx <<< 1;
                    r_sy  <= r_sy <<< 1;
                    if (oct_next == r_cnt) begin
                        r_state <= S_DONE;
                    end else begin
                        r_oct   <= oct_next;
                        r_state <= S_SQX;
                    end
                end
                S_DONE: begin
                    if (i_ctl.ack) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stat.idle = (r_state == S_IDLE);
    assign o_stat.done = (r_state == S_DONE);
    assign o_stat.sum  = r_sum;

endmodule

`default_nettype wire

[rtl/value_noise_fbm_2d.sv]
// Top level of the 2D value-noise fBm block: APB register, handshakes, result register.
// Depends on vnf_pkg and instantiates vnf_seq.
`default_nettype none

// Takes one point (x, y) in signed Q16.16 and returns the sum of octave_count
// octaves of bilinearly interpolated lattice value noise as signed Q2.30.
// Octave i doubles the point i times, hashes its four lattice corners to values
// in (-1, 1], smooths the fraction with the cubic smoothstep, interpolates and
// adds the result weighted by 2^-(i+1). An octave_count of zero gives zero;
// counts above MAX_OCTAVES act as MAX_OCTAVES. Every product goes through one
// shared 33x33 multiplier, and each octave uses it in turn for the smoothstep
// weights, the corner seed, each corner hash, and the interpolation and
// accumulation. A word keeps o_ready low while its octaves run, and longer
// while the sum waits for a full output register; o_valid rises at the edge
// that hands the sum to the output register. The output register lets the
// next word enter while a finished result still waits for i_ready. The single
// register, octave_count (5 bits, reset 4), sits at byte address 0 of the APB
// port; write it only while the block is idle.
module value_noise_fbm_2d #(
    parameter int MAX_OCTAVES     = vnf_pkg::MAX_OCTAVES_DEF,
    parameter int COORD_FRAC_BITS = vnf_pkg::COORD_FRAC_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // input channel
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic signed [vnf_pkg::COORD_W-1:0]  i_x_coord,
    input  wire logic signed [vnf_pkg::COORD_W-1:0]  i_y_coord,
    // result channel
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic signed [vnf_pkg::NOISE_W-1:0]       o_noise_value,
    // configuration port
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [vnf_pkg::APB_AW-1:0]          paddr,
    input  wire logic [vnf_pkg::APB_DW-1:0]          pwdata,
    output logic [vnf_pkg::APB_DW-1:0]               prdata,
    output logic                                     pready
);

    logic [vnf_pkg::CFG_W-1:0]    r_octave;
    logic                         r_out_valid;
    logic [vnf_pkg::NOISE_W-1:0]  r_out_data;

    vnf_pkg::t_seq_ctl            seq_ctl;
    vnf_pkg::t_seq_stat           seq_stat;
    logic                         cfg_wr;
    logic                         reg_sel;

    // APB: no wait states; decode on the word index above the byte offset
    assign pready  = 1'b1;
    assign reg_sel = (paddr[vnf_pkg::APB_AW-1:2] == vnf_pkg::IDX_OCTAVE);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = reg_sel ? vnf_pkg::APB_DW'(r_octave) : '0;

    // Start on an accepted word; hand the sum over when the result register
    // is empty or being drained in the same cycle.
    assign seq_ctl.start = i_valid && o_ready;
    assign seq_ctl.ack   = seq_stat.done && (!r_out_valid || i_ready);
    assign seq_ctl.count = r_octave;

    vnf_seq #(
        .MAX_OCTAVES     (MAX_OCTAVES),
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (seq_ctl),
        .i_x     (i_x_coord),
        .i_y     (i_y_coord),
        .o_stat  (seq_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_octave    <= vnf_pkg::OCTAVE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr && reg_sel) begin
                r_octave <= pwdata[vnf_pkg::CFG_W-1:0];
            end
            // load a new result, else drop the one just taken
            if (seq_ctl.ack) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_ctl.ack) begin
            r_out_data <= seq_stat.sum;
        end
    end

    assign o_ready       = seq_stat.idle;
    assign o_valid       = r_out_valid;
    assign o_noise_value = r_out_data;

endmodule

`default_nettype wire

[rtl/vnf_checker.sv]
// Port-level checks for value_noise_fbm_2d, attached by a bind statement.
// Depends on the top level's port list only.
`default_nettype none

module vnf_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic        o_ready,
    input  wire logic        o_valid,
    input  wire logic        i_ready,
    input  wire logic [31:0] o_noise_value,
    input  wire logic        pready
);

    // a result word waiting for the sink holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_noise_value)))
        else $error("result word changed or dropped while stalled");

    // the input side is busy in the cycle after an accepted word
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input ready right after an accepted word");

    // the input side frees up only when a result is handed to the output
    a_ready_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(o_ready) && $past(i_rst_n)) |-> o_valid)
        else $error("input ready returned without a result word");

    // the configuration port never inserts wait states
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind value_noise_fbm_2d vnf_checker u_vnf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_noise_value (o_noise_value),
    .pready        (pready)
);

`default_nettype wire
